[design/psvm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphonic sine voice mixer package
// Shared types, sizes and constant tables of the voice mixer.
// ----------------------------------------------------------------------------
package psvm_pkg;

    // Sizes of the voice store and of the sine and note tables.
    localparam int VOICE_COUNT      = 16;
    localparam int SLOT_W           = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_W           = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
    localparam int SAMPLE_RATE      = 44100;
    localparam int NOTE_COUNT       = 128;

    // Envelope and register constants, Q1.15.
    localparam logic [15:0] ENV_ONE       = 16'd32768;
    localparam logic [15:0] ATTACK_RESET  = 16'd3277;
    localparam logic [15:0] RELEASE_RESET = 16'd3277;

    // Datapath widths of the voice term and the mix.
    localparam int SINE_OUT_W = 16;
    localparam int P1_W       = SINE_OUT_W + 10;
    localparam int P2_W       = P1_W + 17;
    localparam int ENV_SHIFT  = 23;
    localparam int TERM_W     = P2_W - ENV_SHIFT;
    localparam int ACC_W      = TERM_W + SLOT_W + 1;
    localparam logic signed [P2_W-1:0]  TRUNC_BIAS = P2_W'((64'd1 << ENV_SHIFT) - 64'd1);
    localparam logic signed [ACC_W-1:0] SUM_MAX    = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SUM_MIN    = -ACC_W'(32768);

    // Request codes.
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic {
        CFG_ATTACK  = 1'b0,
        CFG_RELEASE = 1'b1
    } t_cfg_idx;

    // Envelope stage of a voice slot.
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_ATTACK  = 2'd1,
        ST_SUSTAIN = 2'd2,
        ST_RELEASE = 2'd3
    } t_stage;

    typedef logic [SLOT_W-1:0] t_slot;

    // One entry of the voice memory.
    typedef struct packed {
        logic [31:0] phase;
        logic [31:0] step;
        logic [8:0]  amp;
        logic [15:0] env;
    } t_voice;

    typedef logic [31:0] t_step_table [NOTE_COUNT];
    typedef logic [14:0] t_qsine_table [QUARTER];

    // Top octave of note frequencies in Q16.16 Hz, notes 120 to 131.
    localparam logic [31:0] TOP_OCTAVE [12] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
    };

    // Phase step per note: octave shift with rounding, then scale to one turn.
    function automatic t_step_table build_step_table();
        t_step_table     tab;
        longint unsigned f;
        int              sh;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            sh = 10 - (n / 12);
            f  = 64'(TOP_OCTAVE[n % 12]);
            if (sh > 0) begin
                f = (f + (64'd1 << (sh - 1))) >> sh;
            end
            f = ((f << 16) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
            tab[n] = f[31:0];
        end
        return tab;
    endfunction

    // Quarter-wave sine magnitude in Q15 from the odd polynomial in Q30.
    function automatic logic [14:0] sine_mag(input int unsigned k);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned p;
        longint unsigned r;
        t  = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
        t2 = (t * t) >> 30;
        p  = 64'd85569306 - ((64'd5026994 * t2) >> 30);
        p  = 64'd693598640 - ((p * t2) >> 30);
        p  = 64'd1686629713 - ((p * t2) >> 30);
        r  = (p * t) >> 30;
        r  = (r + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return 15'(r);
    endfunction

    function automatic t_qsine_table build_qsine_table();
        t_qsine_table tab;
        for (int k = 0; k < QUARTER; k++) begin
            tab[k] = sine_mag(k);
        end
        return tab;
    endfunction

    localparam t_step_table  STEP_TABLE  = build_step_table();
    localparam t_qsine_table QSINE_TABLE = build_qsine_table();
    localparam logic [14:0]  SINE_PEAK   = sine_mag(QUARTER);

endpackage
`default_nettype wire

[design/psvm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module psvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[design/polyphonic_sine_voice_mixer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polyphonic sine voice mixer
// Voice slots with a linear attack and release envelope, mixed per tick.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// A note-on request loads a slot: phase step from the note
// table, amplitude from the velocity, zero phase and envelope, attack stage.
// A note-off request moves a sounding slot to release.
// Both give no result and leave busy low.
// A tick request raises busy and walks all VOICE_COUNT slots through the
// voice memory, one slot per cycle, with a read-modify-write of each entry.
// The read port of that memory sets the pace. The mixed sample comes out
// with o_valid high for exactly one cycle; busy falls in that same cycle,
// so the next request can be taken while the result is shown.
// The receiver has no way to stall the result; it must take it when shown.
// Configuration writes through i_cfg_we are taken at once and belong to
// idle periods. Reset puts every slot in the idle stage and loads both
// envelope rates with their defaults; the voice memory needs no clearing.
// ----------------------------------------------------------------------------
module polyphonic_sine_voice_mixer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [3:0]  i_voice_slot,
    input  wire logic [6:0]  i_note_number,
    input  wire logic [8:0]  i_velocity,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    output logic [4:0]       o_active_voices
);

    localparam psvm_pkg::t_slot LAST_SLOT = psvm_pkg::t_slot'(psvm_pkg::VOICE_COUNT - 1);
    localparam logic [psvm_pkg::SINE_W-2:0] QUARTER_K =
        (psvm_pkg::SINE_W - 1)'(psvm_pkg::QUARTER);

    // Control and configuration registers.
    logic                  r_busy;
    logic                  r_rd_run;
    psvm_pkg::t_slot       r_rd_idx;
    logic [15:0]           r_attack;
    logic [15:0]           r_release;
    psvm_pkg::t_stage      r_stage [psvm_pkg::VOICE_COUNT];

    // Pipeline registers.
    logic                  r_s1_vld;
    logic                  r_s1_last;
    psvm_pkg::t_slot       r_s1_idx;
    logic                  r_s2_vld;
    logic                  r_s2_last;
    logic signed [15:0]    r_s2_sine;
    logic [8:0]            r_s2_amp;
    logic [15:0]           r_s2_env;
    logic                  r_s3_vld;
    logic                  r_s3_last;
    logic signed [psvm_pkg::P1_W-1:0] r_s3_p1;
    logic [15:0]           r_s3_env;
    logic                  r_s4_vld;
    logic                  r_s4_last;
    logic signed [psvm_pkg::P2_W-1:0] r_s4_p2;
    logic                  r_s5_vld;
    logic                  r_s5_last;
    logic signed [psvm_pkg::TERM_W-1:0] r_s5_term;
    logic signed [psvm_pkg::ACC_W-1:0]  r_acc;
    logic [4:0]            r_active;
    logic                  r_valid;
    logic signed [15:0]    r_sample;
    logic [4:0]            r_active_out;

    // Combinational signals.
    logic                  accept;
    logic                  tick_go;
    logic                  slot_ok;
    psvm_pkg::t_slot       slot;
    psvm_pkg::t_slot       stg_idx;
    psvm_pkg::t_stage      stg_cur;
    logic                  stg_we;
    psvm_pkg::t_stage      stg_wdata;
    logic                  ram_we;
    psvm_pkg::t_slot       ram_waddr;
    psvm_pkg::t_voice      ram_wdata;
    logic [$bits(psvm_pkg::t_voice)-1:0] ram_rdata;
    psvm_pkg::t_voice      voice;
    logic                  live;
    logic [16:0]           env_sum;
    logic [15:0]           n_env;
    psvm_pkg::t_stage      n_stage;
    logic [psvm_pkg::SINE_W-1:0] sidx;
    logic [1:0]            quad;
    logic [psvm_pkg::SINE_W-2:0] qk;
    logic [14:0]           mag;
    logic signed [15:0]    sine;
    logic signed [psvm_pkg::P2_W-1:0]  p2_adj;
    logic signed [psvm_pkg::ACC_W-1:0] acc_sum;
    logic signed [15:0]    sat_sum;
    logic                  mix_done;

    assign accept  = start & ~r_busy;
    assign tick_go = accept & (i_opcode == psvm_pkg::OP_TICK);
    assign slot_ok = 32'(i_voice_slot) < psvm_pkg::VOICE_COUNT;
    assign slot    = psvm_pkg::t_slot'(i_voice_slot);

    // The stage array has one read address: the walk while busy, the request otherwise.
    assign stg_idx = r_busy ? r_s1_idx : slot;
    assign stg_cur = r_stage[stg_idx];

    // Voice memory: phase, step, amplitude and envelope of every slot.
    psvm_ram #(
        .WIDTH ($bits(psvm_pkg::t_voice)),
        .DEPTH (psvm_pkg::VOICE_COUNT)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign voice = psvm_pkg::t_voice'(ram_rdata);
    assign live  = r_s1_vld & (stg_cur != psvm_pkg::ST_IDLE);

    // Envelope ramp of the slot that the memory just returned.
    always_comb begin
        env_sum = {1'b0, voice.env} + {1'b0, r_attack};
        n_env   = voice.env;
        n_stage = stg_cur;
        case (stg_cur)
            psvm_pkg::ST_ATTACK: begin
                if (env_sum >= {1'b0, psvm_pkg::ENV_ONE}) begin
                    n_env   = psvm_pkg::ENV_ONE;
                    n_stage = psvm_pkg::ST_SUSTAIN;
                end else begin
                    n_env = env_sum[15:0];
                end
            end
            psvm_pkg::ST_RELEASE: begin
                if (voice.env <= r_release) begin
                    n_env   = '0;
                    n_stage = psvm_pkg::ST_IDLE;
                end else begin
                    n_env = voice.env - r_release;
                end
            end
            default: begin
                n_env   = voice.env;
                n_stage = stg_cur;
            end
        endcase
    end

    // Write-back of the walk, the load of a note-on request, or the release of a note-off request.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = '{phase: '0,
                      step:  psvm_pkg::STEP_TABLE[i_note_number],
                      amp:   i_velocity,
                      env:   '0};
        stg_we    = 1'b0;
        stg_wdata = psvm_pkg::ST_ATTACK;
        if (r_busy) begin
            ram_we    = live;
            ram_waddr = r_s1_idx;
            ram_wdata = '{phase: voice.phase + voice.step,
                          step:  voice.step,
                          amp:   voice.amp,
                          env:   n_env};
            stg_we    = live;
            stg_wdata = n_stage;
        end else if (accept && slot_ok) begin
            unique case (i_opcode)
                psvm_pkg::OP_NOTE_ON: begin
                    ram_we    = 1'b1;
                    stg_we    = 1'b1;
                    stg_wdata = psvm_pkg::ST_ATTACK;
                end
                psvm_pkg::OP_NOTE_OFF: begin
                    stg_we    = (stg_cur != psvm_pkg::ST_IDLE);
                    stg_wdata = psvm_pkg::ST_RELEASE;
                end
                default: begin
                    ram_we = 1'b0;
                    stg_we = 1'b0;
                end
            endcase
        end
    end

    // Sine lookup from the quarter-wave table, mirrored and negated by quadrant.
    always_comb begin
        sidx = voice.phase[31 -: psvm_pkg::SINE_W];
        quad = sidx[psvm_pkg::SINE_W-1 -: 2];
        qk   = quad[0] ? (QUARTER_K - {1'b0, sidx[psvm_pkg::SINE_W-3:0]})
                       : {1'b0, sidx[psvm_pkg::SINE_W-3:0]};
        mag  = (qk == QUARTER_K) ? psvm_pkg::SINE_PEAK
                                 : psvm_pkg::QSINE_TABLE[qk[psvm_pkg::SINE_W-3:0]];
        sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // Truncation toward zero of the voice term, then the running mix.
    always_comb begin
        p2_adj  = r_s4_p2 + (r_s4_p2[psvm_pkg::P2_W-1] ? psvm_pkg::TRUNC_BIAS : '0);
        acc_sum = r_acc + psvm_pkg::ACC_W'(r_s5_term);
        if (acc_sum > psvm_pkg::SUM_MAX) begin
            sat_sum = 16'sd32767;
        end else if (acc_sum < psvm_pkg::SUM_MIN) begin
            sat_sum = -16'sd32768;
        end else begin
            sat_sum = acc_sum[15:0];
        end
        mix_done = r_s5_vld & r_s5_last;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= psvm_pkg::ATTACK_RESET;
            r_release <= psvm_pkg::RELEASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psvm_pkg::CFG_ATTACK:  r_attack  <= i_cfg_data;
                psvm_pkg::CFG_RELEASE: r_release <= i_cfg_data;
                default:               r_attack  <= r_attack;
            endcase
        end
    end

    // Envelope stage of every slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < psvm_pkg::VOICE_COUNT; k++) begin
                r_stage[k] <= psvm_pkg::ST_IDLE;
            end
        end else if (stg_we) begin
            r_stage[stg_idx] <= stg_wdata;
        end
    end

    // Busy flag and the read walk over the slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_run <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            if (tick_go) begin
                r_busy <= 1'b1;
            end else if (mix_done) begin
                r_busy <= 1'b0;
            end
            if (tick_go) begin
                r_rd_run <= 1'b1;
                r_rd_idx <= '0;
            end else if (r_rd_run) begin
                r_rd_run <= (r_rd_idx != LAST_SLOT);
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // Valid and last flags along the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_s1_vld <= r_rd_run;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_valid  <= mix_done;
        end
    end

    // Datapath: sine, two multiplies, truncation and the mix.
    // Idle slots feed zeros, since their memory entries may never have been written.
    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_rd_idx;
        r_s1_last <= r_rd_run & (r_rd_idx == LAST_SLOT);
        r_s2_last <= r_s1_last;
        r_s2_sine <= live ? sine : '0;
        r_s2_amp  <= live ? voice.amp : '0;
        r_s2_env  <= live ? voice.env : '0;
        r_s3_last <= r_s2_last;
        r_s3_p1   <= r_s2_sine * $signed({1'b0, r_s2_amp});
        r_s3_env  <= r_s2_env;
        r_s4_last <= r_s3_last;
        r_s4_p2   <= r_s3_p1 * $signed({1'b0, r_s3_env});
        r_s5_last <= r_s4_last;
        r_s5_term <= p2_adj[psvm_pkg::P2_W-1:psvm_pkg::ENV_SHIFT];
        if (tick_go) begin
            r_acc    <= '0;
            r_active <= '0;
        end else begin
            if (r_s5_vld) begin
                r_acc <= acc_sum;
            end
            if (live && (n_stage != psvm_pkg::ST_IDLE)) begin
                r_active <= r_active + 1'b1;
            end
        end
        if (mix_done) begin
            r_sample     <= sat_sum;
            r_active_out <= r_active;
        end
    end

    assign busy            = r_busy;
    assign o_valid         = r_valid;
    assign o_left_sample   = r_sample;
    assign o_right_sample  = r_sample;
    assign o_active_voices = r_active_out;

`ifndef SYNTHESIS
    // A result follows the end of a tick walk and ends the busy period.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_busy) && !r_busy))
        else $error("result without a preceding tick walk");

    // The walk only runs while busy.
    a_walk_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_run || r_s1_vld || r_s5_vld) |-> r_busy)
        else $error("voice walk outside of a busy period");

    // The reported voice count never exceeds the slot count.
    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_active_voices) <= psvm_pkg::VOICE_COUNT))
        else $error("active voice count out of range");

    // A tick request starts the walk at the first slot in the next cycle.
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_go |=> (r_rd_run && (r_rd_idx == '0)))
        else $error("tick request did not start the slot walk");
`endif

endmodule
`default_nettype wire
